// ===== src/fpm_pkg.sv =====
// Shared types, constants and helper functions for the frequency/period meter post-processor.
package fpm_pkg;

  // Field widths and fixed-point format
  localparam int FRAC_BITS       = 8;
  localparam int CNT_W           = 32;
  localparam int BASE_W          = CNT_W + FRAC_BITS;      // gate count in fixed point
  localparam int FREQ_W          = 48;
  localparam int K_W             = 34;                     // holds 1e10
  localparam int DIV_W           = K_W + FRAC_BITS + 1;    // dividend / quotient width
  localparam int DIV_CNT_W       = $clog2(DIV_W);
  localparam int FX_W            = FREQ_W + 4;             // room for x10 / x11
  localparam int LOW_COUNT_LIMIT = 1000;
  localparam int ADDR_W          = 4;
  localparam int DATA_W          = 32;

  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

  // Gate time selector codes
  localparam logic [1:0] GATE_100MS = 2'd0;
  localparam logic [1:0] GATE_1S    = 2'd1;
  localparam logic [1:0] GATE_10S   = 2'd2;

  // Period multiplier selector codes
  localparam logic [1:0] PER_X1   = 2'd0;
  localparam logic [1:0] PER_X10  = 2'd1;
  localparam logic [1:0] PER_X100 = 2'd2;

  // Register map, indexed by paddr[3:2]
  typedef enum logic [1:0] {
    REG_METER_EN  = 2'd0,
    REG_GATE_TIME = 2'd1,
    REG_REF_CLOCK = 2'd2,
    REG_PERIODS   = 2'd3
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GATE,
    ST_DIV,
    ST_TEST1,
    ST_TEST2,
    ST_TEST3,
    ST_PERIOD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              gate_done;
    logic              period_done;
    logic              gate_ovf;
    logic              period_ovf;
    logic              freq_busy;
    logic              period_busy;
    logic [CNT_W-1:0]  gate_count;
    logic [CNT_W-1:0]  period_count;
  } poll_t;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency_hz;
    logic              freq_error;
    logic              period_mode;
    logic              lamp_gate;
    logic              lamp_period;
    logic [CNT_W-1:0]  shown_gate_count;
    logic [CNT_W-1:0]  shown_period_count;
  } result_t;

  // Reference constant times period multiplier
  function automatic logic [K_W-1:0] period_k(logic enabled, logic [1:0] ref_sel,
                                               logic [1:0] per_sel);
    logic [1:0]     ps;
    logic [63:0]    k;
    ps = (per_sel == 2'd3) ? PER_X100 : per_sel;
    case ({ref_sel, ps})
      {2'd0, PER_X1}:   k = 64'd100000;
      {2'd0, PER_X10}:  k = 64'd1000000;
      {2'd0, PER_X100}: k = 64'd10000000;
      {2'd1, PER_X1}:   k = 64'd1000000;
      {2'd1, PER_X10}:  k = 64'd10000000;
      {2'd1, PER_X100}: k = 64'd100000000;
      {2'd2, PER_X1}:   k = 64'd10000000;
      {2'd2, PER_X10}:  k = 64'd100000000;
      {2'd2, PER_X100}: k = 64'd1000000000;
      {2'd3, PER_X1}:   k = 64'd100000000;
      {2'd3, PER_X10}:  k = 64'd1000000000;
      {2'd3, PER_X100}: k = 64'd10000000000;
      default:          k = 64'd1000000;
    endcase
    if (!enabled) begin
      k = 64'd1000000;
    end
    return k[K_W-1:0];
  endfunction

  // Clamp a wide frequency to the output range
  function automatic logic [FREQ_W-1:0] sat_freq(logic [FX_W-1:0] v);
    return (v > FX_W'(FREQ_MAX)) ? FREQ_MAX : v[FREQ_W-1:0];
  endfunction

endpackage

// ===== src/freq_period_meter_postproc.sv =====
// Top level: frequency/period meter post-processor with APB config and shared divider.
// Flow: a poll passes ST_GATE and ST_PERIOD on its way to ST_OUT; a reading taken
//   adds the ST_TEST1..ST_TEST3 deviation test, and a 10 s gate reading or a nonzero period count
//   first runs the DIV_W = 43 bit restoring divider, one quotient bit per cycle.
// A new poll is taken only in ST_IDLE, after the last result is registered; result stalls hold ST_OUT.
// Reset (rst, synchronous): config to enabled / 1 s gate / 1e5 ref / x1, control state cleared.
module freq_period_meter_postproc (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        poll_valid,
  output logic                        poll_ready,
  input  fpm_pkg::poll_t              poll,
  output logic                        result_valid,
  input  logic                        result_ready,
  output fpm_pkg::result_t            result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fpm_pkg::ADDR_W-1:0]  paddr,
  input  logic [fpm_pkg::DATA_W-1:0]  pwdata,
  output logic [fpm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  // Config registers
  logic       meter_enabled;
  logic [1:0] gate_time_sel;
  logic [1:0] ref_clock_sel;
  logic [1:0] periods_sel;

  // Sequencer and block state
  fpm_pkg::state_t              state, state_next;
  fpm_pkg::poll_t               item;
  logic                         use_period;
  logic [fpm_pkg::FREQ_W-1:0]   prev_freq;
  logic [fpm_pkg::FREQ_W-1:0]   acc_freq;
  logic                         err_flag;
  logic                         gate_lamp;
  logic                         period_lamp;
  logic [fpm_pkg::CNT_W-1:0]    gate_shown;
  logic [fpm_pkg::CNT_W-1:0]    period_shown;
  logic                         phase_period;
  logic [fpm_pkg::FREQ_W-1:0]   freq_val;

  // Shared divider
  logic [fpm_pkg::DIV_W-1:0]     div_quo;
  logic [fpm_pkg::CNT_W-1:0]     div_rem;
  logic [fpm_pkg::CNT_W-1:0]     div_den;
  logic [fpm_pkg::DIV_CNT_W-1:0] div_cnt;

  // Deviation test
  logic [fpm_pkg::FX_W-1:0]     f10;
  logic [fpm_pkg::FX_W-1:0]     bound;
  logic                         below;

  // Combinational helpers
  logic                         cfg_wr;
  logic                         out_free;
  logic [1:0]                   gate_sel_eff;
  logic                         gate_take;
  logic                         period_take;
  logic [fpm_pkg::BASE_W-1:0]   gate_base;
  logic [fpm_pkg::FX_W-1:0]     gate_x10;
  logic [fpm_pkg::DIV_W-1:0]    gate_dividend;
  logic [fpm_pkg::DIV_W-1:0]    period_dividend;
  logic [fpm_pkg::CNT_W:0]      rem_sh;
  logic [fpm_pkg::CNT_W:0]      rem_diff;
  logic                         q_bit;
  logic [fpm_pkg::DIV_W-1:0]    quo_step;
  logic [fpm_pkg::CNT_W-1:0]    rem_step;
  logic                         reject;

  // APB port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      meter_enabled <= 1'b1;
      gate_time_sel <= fpm_pkg::GATE_1S;
      ref_clock_sel <= 2'd0;
      periods_sel   <= fpm_pkg::PER_X1;
    end else if (cfg_wr) begin
      case (fpm_pkg::reg_idx_t'(paddr[3:2]))
        fpm_pkg::REG_METER_EN:  meter_enabled <= pwdata[0];
        fpm_pkg::REG_GATE_TIME: gate_time_sel <= pwdata[1:0];
        fpm_pkg::REG_REF_CLOCK: ref_clock_sel <= pwdata[1:0];
        fpm_pkg::REG_PERIODS:   periods_sel   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (fpm_pkg::reg_idx_t'(paddr[3:2]))
      fpm_pkg::REG_METER_EN:  prdata = fpm_pkg::DATA_W'(meter_enabled);
      fpm_pkg::REG_GATE_TIME: prdata = fpm_pkg::DATA_W'(gate_time_sel);
      fpm_pkg::REG_REF_CLOCK: prdata = fpm_pkg::DATA_W'(ref_clock_sel);
      fpm_pkg::REG_PERIODS:   prdata = fpm_pkg::DATA_W'(periods_sel);
      default:                prdata = '0;
    endcase
  end

  // Reading decode
  assign poll_ready   = (state == fpm_pkg::ST_IDLE);
  assign out_free     = !result_valid || result_ready;
  assign gate_sel_eff = !meter_enabled ? fpm_pkg::GATE_100MS :
                        (gate_time_sel == 2'd3) ? fpm_pkg::GATE_10S : gate_time_sel;
  assign gate_take    = item.gate_done && !use_period &&
                        (item.gate_count >= fpm_pkg::CNT_W'(fpm_pkg::LOW_COUNT_LIMIT));
  assign period_take  = item.period_done && use_period;
  assign gate_base    = {item.gate_count, {fpm_pkg::FRAC_BITS{1'b0}}};
  assign gate_x10     = (fpm_pkg::FX_W'(gate_base) << 3) + (fpm_pkg::FX_W'(gate_base) << 1);
  assign gate_dividend   = fpm_pkg::DIV_W'(gate_base) + fpm_pkg::DIV_W'(5);
  assign period_dividend =
      (fpm_pkg::DIV_W'(fpm_pkg::period_k(meter_enabled, ref_clock_sel, periods_sel))
       << fpm_pkg::FRAC_BITS) + fpm_pkg::DIV_W'(item.period_count >> 1);

  // Divider step: one quotient bit per cycle
  assign rem_sh   = {div_rem, div_quo[fpm_pkg::DIV_W-1]};
  assign rem_diff = rem_sh - {1'b0, div_den};
  assign q_bit    = !rem_diff[fpm_pkg::CNT_W];
  assign rem_step = q_bit ? rem_diff[fpm_pkg::CNT_W-1:0] : rem_sh[fpm_pkg::CNT_W-1:0];
  assign quo_step = {div_quo[fpm_pkg::DIV_W-2:0], q_bit};

  // Outside 0.9 .. 1.1 of previous
  assign reject = below || (f10 > bound);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      fpm_pkg::ST_IDLE: begin
        if (poll_valid) state_next = fpm_pkg::ST_GATE;
      end
      fpm_pkg::ST_GATE: begin
        if (!gate_take) begin
          state_next = fpm_pkg::ST_PERIOD;
        end else if (gate_sel_eff == fpm_pkg::GATE_10S) begin
          state_next = fpm_pkg::ST_DIV;
        end else begin
          state_next = fpm_pkg::ST_TEST1;
        end
      end
      fpm_pkg::ST_DIV: begin
        if (div_cnt == '0) state_next = fpm_pkg::ST_TEST1;
      end
      fpm_pkg::ST_TEST1: state_next = fpm_pkg::ST_TEST2;
      fpm_pkg::ST_TEST2: state_next = fpm_pkg::ST_TEST3;
      fpm_pkg::ST_TEST3: begin
        state_next = phase_period ? fpm_pkg::ST_OUT : fpm_pkg::ST_PERIOD;
      end
      fpm_pkg::ST_PERIOD: begin
        if (!period_take) begin
          state_next = fpm_pkg::ST_OUT;
        end else if (item.period_count == '0) begin
          state_next = fpm_pkg::ST_TEST1;
        end else begin
          state_next = fpm_pkg::ST_DIV;
        end
      end
      fpm_pkg::ST_OUT: begin
        if (out_free) state_next = fpm_pkg::ST_IDLE;
      end
      default: state_next = fpm_pkg::ST_IDLE;
    endcase
  end

  // Datapath and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      use_period   <= 1'b0;
      prev_freq    <= '0;
      acc_freq     <= '0;
      err_flag     <= 1'b0;
      gate_lamp    <= 1'b0;
      period_lamp  <= 1'b0;
      gate_shown   <= '0;
      period_shown <= '0;
      phase_period <= 1'b0;
    end else begin
      case (state)
        fpm_pkg::ST_IDLE: begin
          if (poll_valid) begin
            // lamps latch on busy, clear on ready
            if (!gate_lamp) begin
              gate_lamp <= poll.freq_busy;
            end else if (poll.gate_done) begin
              gate_lamp <= 1'b0;
            end
            if (!period_lamp) begin
              period_lamp <= poll.period_busy;
            end else if (poll.period_done) begin
              period_lamp <= 1'b0;
            end
          end
        end
        fpm_pkg::ST_GATE: begin
          phase_period <= 1'b0;
          if (item.gate_done) begin
            gate_shown <= item.gate_count;
            if (!use_period && !gate_take) use_period <= 1'b1;
          end
        end
        fpm_pkg::ST_TEST3: begin
          if (reject) begin
            err_flag <= 1'b1;
          end else begin
            err_flag <= 1'b0;
            acc_freq <= freq_val;
          end
          prev_freq <= freq_val;
        end
        fpm_pkg::ST_PERIOD: begin
          phase_period <= 1'b1;
          if (item.period_done) period_shown <= item.period_count;
          if (period_take) use_period <= 1'b0;
        end
        fpm_pkg::ST_OUT: begin
          // overflow clears after the readings
          if (out_free) begin
            if (item.gate_ovf) gate_shown <= '0;
            if (item.period_ovf) period_shown <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers: item, divider, frequency, test terms
  always_ff @(posedge clk) begin
    case (state)
      fpm_pkg::ST_IDLE: begin
        if (poll_valid) item <= poll;
      end
      fpm_pkg::ST_GATE: begin
        freq_val <= (gate_sel_eff == fpm_pkg::GATE_1S) ?
                    fpm_pkg::sat_freq(fpm_pkg::FX_W'(gate_base)) :
                    fpm_pkg::sat_freq(gate_x10);
        div_quo  <= gate_dividend;
        div_rem  <= '0;
        div_den  <= fpm_pkg::CNT_W'(10);
        div_cnt  <= fpm_pkg::DIV_CNT_W'(fpm_pkg::DIV_W - 1);
      end
      fpm_pkg::ST_PERIOD: begin
        freq_val <= '0;
        div_quo  <= period_dividend;
        div_rem  <= '0;
        div_den  <= item.period_count;
        div_cnt  <= fpm_pkg::DIV_CNT_W'(fpm_pkg::DIV_W - 1);
      end
      fpm_pkg::ST_DIV: begin
        div_quo <= quo_step;
        div_rem <= rem_step;
        div_cnt <= div_cnt - 1'b1;
        if (div_cnt == '0) freq_val <= fpm_pkg::sat_freq(fpm_pkg::FX_W'(quo_step));
      end
      fpm_pkg::ST_TEST1: begin
        f10   <= (fpm_pkg::FX_W'(freq_val) << 3) + (fpm_pkg::FX_W'(freq_val) << 1);
        bound <= (fpm_pkg::FX_W'(prev_freq) << 3) + fpm_pkg::FX_W'(prev_freq);
      end
      fpm_pkg::ST_TEST2: begin
        below <= (f10 < bound);
        bound <= bound + (fpm_pkg::FX_W'(prev_freq) << 1);
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == fpm_pkg::ST_OUT && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == fpm_pkg::ST_OUT && out_free) begin
      result.frequency_hz       <= acc_freq;
      result.freq_error         <= err_flag;
      result.period_mode        <= use_period;
      result.lamp_gate          <= gate_lamp;
      result.lamp_period        <= period_lamp;
      result.shown_gate_count   <= item.gate_ovf ? '0 : gate_shown;
      result.shown_period_count <= item.period_ovf ? '0 : period_shown;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_poll: assert property (@(posedge clk) disable iff (rst)
    (poll_valid && poll_ready) |=> !poll_ready)
    else $error("poll taken while a poll is still in work");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == fpm_pkg::ST_DIV && div_cnt == '0) |=> (state == fpm_pkg::ST_TEST1))
    else $error("divider did not hand over to the deviation test");

  a_accept_clears_error: assert property (@(posedge clk) disable iff (rst)
    (state == fpm_pkg::ST_TEST3 && !reject) |=> (!err_flag && acc_freq == $past(freq_val)))
    else $error("accepted reading not latched");

  a_period_leaves_mode: assert property (@(posedge clk) disable iff (rst)
    (state == fpm_pkg::ST_PERIOD && item.period_done) |=> !use_period)
    else $error("period mode kept after a period reading");
`endif

endmodule

// ===== tb/freq_period_meter_postproc_tb.sv =====
// Self-checking testbench for the frequency/period meter post-processor.
module freq_period_meter_postproc_tb;

  localparam int STALL_LIMIT = 4000;
  localparam int END_PAUSE   = 120;
  localparam int PHASES      = 8;
  localparam int RAND_POLLS  = 210;
  localparam logic [63:0] MAX48 = 64'(fpm_pkg::FREQ_MAX);

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       poll_valid = 1'b0;
  logic                       poll_ready;
  fpm_pkg::poll_t             poll_in = '0;
  logic                       result_valid;
  logic                       result_ready = 1'b0;
  fpm_pkg::result_t           readout;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [fpm_pkg::ADDR_W-1:0] paddr = '0;
  logic [fpm_pkg::DATA_W-1:0] pwdata = '0;
  logic [fpm_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  freq_period_meter_postproc u_top (
    .clk          (clk),
    .rst          (rst),
    .poll_valid   (poll_valid),
    .poll_ready   (poll_ready),
    .poll         (poll_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (readout),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // Polls waiting to be sent and readouts waiting to arrive
  fpm_pkg::poll_t   poll_backlog[$];
  fpm_pkg::result_t pending_readouts[$];

  // Predicted meter state and register copies
  logic        cfg_meter_en = 1'b1;
  logic [1:0]  cfg_gate_sel = fpm_pkg::GATE_1S;
  logic [1:0]  cfg_ref_sel  = 2'd0;
  logic [1:0]  cfg_per_sel  = fpm_pkg::PER_X1;
  logic        mdl_period_wait = 1'b0;
  logic [63:0] mdl_prev_freq   = '0;
  logic [63:0] mdl_shown_freq  = '0;
  logic        mdl_error       = 1'b0;
  logic        mdl_gate_lamp   = 1'b0;
  logic        mdl_period_lamp = 1'b0;
  logic [31:0] mdl_gate_shown  = '0;
  logic [31:0] mdl_period_shown = '0;

  // Stimulus shaping
  logic [31:0] nom_gate   = 32'd50000;
  logic [31:0] nom_period = 32'd2000;
  bit          no_idle    = 1'b0;
  int          send_gap   = 0;
  int          hold_left  = 0;

  int fail_count     = 0;
  int polls_taken    = 0;
  int readouts_seen  = 0;
  int period_reads   = 0;
  int rejects        = 0;
  int settings_run   = 1;
  int quiet_cycles   = 0;

  task automatic note_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
    if (fail_count < 10)
      $display("MISMATCH beat %0d %s: expected 0x%0h, got 0x%0h",
               readouts_seen, what, exp_v, got_v);
    fail_count++;
  endtask

  function automatic logic [63:0] clamp48(logic [63:0] v);
    return (v > MAX48) ? MAX48 : v;
  endfunction

  // Gate count to Q40.8 Hz using the gate time scale
  function automatic logic [63:0] gate_freq(logic [31:0] cnt);
    logic [63:0] base;
    logic [1:0]  sel;
    base = {32'd0, cnt} << fpm_pkg::FRAC_BITS;
    sel = (cfg_gate_sel == 2'd3) ? fpm_pkg::GATE_10S : cfg_gate_sel;
    if (!cfg_meter_en || sel == fpm_pkg::GATE_100MS) return clamp48(base * 10);
    if (sel == fpm_pkg::GATE_1S) return clamp48(base);
    return clamp48((base + 64'd5) / 64'd10);
  endfunction

  // Reference constant times period multiplier over the period count, rounded
  function automatic logic [63:0] period_freq(logic [31:0] cnt);
    logic [63:0] k;
    logic [1:0]  ps;
    int          steps;
    if (cnt == 0) return 64'd0;
    k = 64'd1000000;
    if (cfg_meter_en) begin
      ps = (cfg_per_sel == 2'd3) ? fpm_pkg::PER_X100 : cfg_per_sel;
      steps = int'(cfg_ref_sel) + int'(ps);
      k = 64'd100000;
      repeat (steps) k = k * 10;
    end
    return clamp48(((k << fpm_pkg::FRAC_BITS) + {33'd0, cnt[31:1]}) / {32'd0, cnt});
  endfunction

  // Ten percent band around the previous reading
  function automatic void grade_reading(logic [63:0] f);
    if (f * 10 < mdl_prev_freq * 9 || f * 10 > mdl_prev_freq * 11) begin
      mdl_error = 1'b1;
      rejects++;
    end else begin
      mdl_error = 1'b0;
      mdl_shown_freq = f;
    end
    mdl_prev_freq = f;
  endfunction

  function automatic fpm_pkg::result_t compute_readout(fpm_pkg::poll_t p);
    fpm_pkg::result_t r;
    // lamps
    if (!mdl_gate_lamp) begin
      if (p.freq_busy) mdl_gate_lamp = 1'b1;
    end else if (p.gate_done) begin
      mdl_gate_lamp = 1'b0;
    end
    if (!mdl_period_lamp) begin
      if (p.period_busy) mdl_period_lamp = 1'b1;
    end else if (p.period_done) begin
      mdl_period_lamp = 1'b0;
    end
    // gate reading; a low count switches to period mode
    if (p.gate_done) begin
      mdl_gate_shown = p.gate_count;
      if (!mdl_period_wait) begin
        if (p.gate_count < fpm_pkg::LOW_COUNT_LIMIT) mdl_period_wait = 1'b1;
        else grade_reading(gate_freq(p.gate_count));
      end
    end
    // period reading, used only in period mode
    if (p.period_done) begin
      mdl_period_shown = p.period_count;
      if (mdl_period_wait) begin
        grade_reading(period_freq(p.period_count));
        mdl_period_wait = 1'b0;
        period_reads++;
      end
    end
    if (p.gate_ovf) mdl_gate_shown = '0;
    if (p.period_ovf) mdl_period_shown = '0;
    r.frequency_hz       = mdl_shown_freq[fpm_pkg::FREQ_W-1:0];
    r.freq_error         = mdl_error;
    r.period_mode        = mdl_period_wait;
    r.lamp_gate          = mdl_gate_lamp;
    r.lamp_period        = mdl_period_lamp;
    r.shown_gate_count   = mdl_gate_shown;
    r.shown_period_count = mdl_period_shown;
    return r;
  endfunction

  function automatic fpm_pkg::poll_t mk(bit fr, bit pr, bit fo, bit po, bit fb, bit pb,
                                        logic [31:0] g, logic [31:0] c);
    fpm_pkg::poll_t p;
    p.gate_done    = fr;
    p.period_done  = pr;
    p.gate_ovf     = fo;
    p.period_ovf   = po;
    p.freq_busy    = fb;
    p.period_busy  = pb;
    p.gate_count   = g;
    p.period_count = c;
    return p;
  endfunction

  // Count within about six percent of a nominal value
  function automatic logic [31:0] near(logic [31:0] n);
    logic [63:0] w;
    w = ({32'd0, n} * (64'd94 + 64'($urandom_range(0, 12)))) / 64'd100;
    if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
    return w[31:0];
  endfunction

  // Mostly plausible reading sequences, some noise
  function automatic fpm_pkg::poll_t random_poll();
    fpm_pkg::poll_t p;
    int             r;
    r = $urandom_range(0, 99);
    p = mk(0, 0, $urandom_range(0, 19) == 0, $urandom_range(0, 19) == 0,
           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom, $urandom);
    if (r < 15) begin
      p.gate_done   = 1'($urandom_range(0, 1));
      p.period_done = 1'($urandom_range(0, 1));
      p.gate_ovf    = 1'($urandom_range(0, 1));
      p.period_ovf  = 1'($urandom_range(0, 1));
    end else if (r < 55) begin
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 99);
        if (r < 70) nom_gate = $urandom_range(1000, 5000000);
        else if (r < 90) nom_gate = $urandom_range(1000, 32'hFFFF_FFFF);
        else nom_gate = $urandom_range(1000, 1200);
      end
      p.gate_done   = 1'b1;
      p.gate_count  = near(nom_gate);
      p.period_done = ($urandom_range(0, 4) == 0);
    end else if (r < 85) begin
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 99);
        if (r < 60) nom_period = $urandom_range(100, 1000000);
        else if (r < 80) nom_period = $urandom_range(1, 99);
        else nom_period = $urandom;
      end
      p.period_count = near(nom_period);
      case ($urandom_range(0, 2))
        0: begin
          p.gate_done   = 1'b1;
          p.gate_count  = $urandom_range(0, fpm_pkg::LOW_COUNT_LIMIT - 1);
          p.period_done = 1'b1;
        end
        1: begin
          p.gate_done  = 1'b1;
          p.gate_count = $urandom_range(0, fpm_pkg::LOW_COUNT_LIMIT - 1);
        end
        default: p.period_done = 1'b1;
      endcase
    end
    return p;
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Poll driver
  always @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (!poll_valid || poll_ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        poll_valid <= 1'b0;
      end else if (poll_backlog.size() != 0) begin
        poll_in <= poll_backlog.pop_front();
        poll_valid <= 1'b1;
        send_gap <= pick_idle();
      end else begin
        poll_valid <= 1'b0;
      end
    end
  end

  // Result receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      result_ready <= 1'b1;
      if (result_valid && result_ready) hold_left <= pick_idle();
    end
  end

  // Monitor: predict on accepted polls, check accepted readouts
  always @(posedge clk) begin
    fpm_pkg::result_t want;
    if (!rst && poll_valid && poll_ready) begin
      pending_readouts.push_back(compute_readout(poll_in));
      polls_taken++;
    end
    if (!rst && result_valid && result_ready) begin
      if (pending_readouts.size() == 0) begin
        note_mismatch("unexpected beat", 64'd0, 64'(readout.frequency_hz));
      end else begin
        want = pending_readouts.pop_front();
        if (readout.frequency_hz !== want.frequency_hz)
          note_mismatch("frequency_hz", 64'(want.frequency_hz), 64'(readout.frequency_hz));
        if (readout.freq_error !== want.freq_error)
          note_mismatch("freq_error", 64'(want.freq_error), 64'(readout.freq_error));
        if (readout.period_mode !== want.period_mode)
          note_mismatch("period_mode", 64'(want.period_mode), 64'(readout.period_mode));
        if (readout.lamp_gate !== want.lamp_gate)
          note_mismatch("lamp_gate", 64'(want.lamp_gate), 64'(readout.lamp_gate));
        if (readout.lamp_period !== want.lamp_period)
          note_mismatch("lamp_period", 64'(want.lamp_period), 64'(readout.lamp_period));
        if (readout.shown_gate_count !== want.shown_gate_count)
          note_mismatch("shown_gate_count", 64'(want.shown_gate_count),
                        64'(readout.shown_gate_count));
        if (readout.shown_period_count !== want.shown_period_count)
          note_mismatch("shown_period_count", 64'(want.shown_period_count),
                        64'(readout.shown_period_count));
      end
      readouts_seen++;
    end
  end

  // Cycles with no beat on any port
  always @(posedge clk) begin
    if ((poll_valid && poll_ready) || (result_valid && result_ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(negedge clk);
    $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
    $display("freq_period_meter_postproc verification failed");
    $finish;
  end

  // One APB transfer: setup cycle, then access cycle
  task automatic apb_access(bit wr, fpm_pkg::reg_idx_t idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    rdata = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write a register with junk above its width, mirror it, read it back
  task automatic set_register(fpm_pkg::reg_idx_t idx, logic [1:0] v);
    logic [31:0] mask;
    logic [31:0] rd;
    mask = (idx == fpm_pkg::REG_METER_EN) ? 32'd1 : 32'd3;
    apb_access(1'b1, idx, ($urandom & ~mask) | (32'(v) & mask), rd);
    case (idx)
      fpm_pkg::REG_METER_EN:  cfg_meter_en = v[0];
      fpm_pkg::REG_GATE_TIME: cfg_gate_sel = v;
      fpm_pkg::REG_REF_CLOCK: cfg_ref_sel  = v;
      fpm_pkg::REG_PERIODS:   cfg_per_sel  = v;
      default: ;
    endcase
    apb_access(1'b0, idx, 32'd0, rd);
    if (rd !== (32'(v) & mask)) note_mismatch("register readback", 64'(v & mask), 64'(rd));
  endtask

  task automatic wait_drained();
    while (poll_backlog.size() != 0 || poll_valid || pending_readouts.size() != 0)
      @(negedge clk);
  endtask

  // Phases of directed and random polls under different register settings
  initial begin : stimulus
    logic [1:0] en_v, gate_v, ref_v, per_v;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // lamps, band edges, mode switches, zero and max counts, overflow
    poll_backlog.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
    poll_backlog.push_back(mk(0, 0, 0, 0, 1, 1, 0, 0));
    poll_backlog.push_back(mk(1, 0, 0, 0, 0, 0, 10000, 0));
    poll_backlog.push_back(mk(1, 0, 0, 0, 1, 0, 10000, 0));
    poll_backlog.push_back(mk(1, 0, 0, 0, 0, 0, 11000, 0));
    poll_backlog.push_back(mk(1, 0, 0, 0, 0, 0, 9900, 0));
    poll_backlog.push_back(mk(1, 0, 0, 0, 0, 0, 11000, 0));
    poll_backlog.push_back(mk(1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
    poll_backlog.push_back(mk(1, 1, 0, 0, 0, 0, 500, 1000));
    poll_backlog.push_back(mk(0, 1, 0, 0, 0, 1, 0, 1000));
    poll_backlog.push_back(mk(1, 0, 0, 0, 0, 0, 999, 0));
    poll_backlog.push_back(mk(1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
    poll_backlog.push_back(mk(0, 1, 0, 0, 0, 0, 0, 0));
    poll_backlog.push_back(mk(1, 0, 0, 0, 0, 0, 1000, 0));
    poll_backlog.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0));
    poll_backlog.push_back(mk(0, 1, 0, 0, 0, 0, 0, 1));
    poll_backlog.push_back(mk(1, 0, 0, 0, 0, 0, 1, 0));
    poll_backlog.push_back(mk(0, 1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    poll_backlog.push_back(mk(1, 1, 0, 0, 0, 0, 0, 51200000));
    poll_backlog.push_back(mk(1, 1, 1, 1, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    poll_backlog.push_back(mk(0, 0, 1, 0, 0, 0, 5, 6));
    poll_backlog.push_back(mk(1, 1, 0, 1, 0, 0, 2000, 7));
    poll_backlog.push_back(mk(0, 0, 0, 0, 1, 1, 32'hAAAA_AAAA, 32'h5555_5555));
    repeat (RAND_POLLS - 20) poll_backlog.push_back(random_poll());
    wait_drained();

    for (int ph = 1; ph < PHASES; ph++) begin
      case (ph)
        1: begin
          en_v = 2'd1; gate_v = fpm_pkg::GATE_100MS; ref_v = 2'd3; per_v = fpm_pkg::PER_X100;
        end
        2: begin
          en_v = 2'd1; gate_v = fpm_pkg::GATE_10S; ref_v = 2'd0; per_v = fpm_pkg::PER_X1;
        end
        3: begin
          en_v = 2'd0; gate_v = 2'd3; ref_v = 2'd2; per_v = fpm_pkg::PER_X10;
        end
        4: begin en_v = 2'd1; gate_v = 2'd3; ref_v = 2'd1; per_v = 2'd3; end
        default: begin
          en_v   = 2'($urandom_range(0, 1));
          gate_v = 2'($urandom_range(0, 3));
          ref_v  = 2'($urandom_range(0, 3));
          per_v  = 2'($urandom_range(0, 3));
        end
      endcase
      set_register(fpm_pkg::REG_METER_EN, en_v);
      set_register(fpm_pkg::REG_GATE_TIME, gate_v);
      set_register(fpm_pkg::REG_REF_CLOCK, ref_v);
      set_register(fpm_pkg::REG_PERIODS, per_v);
      settings_run++;
      no_idle = (ph % 3 == 2);
      if (ph == 1) begin
        // largest gate count at the 100 ms gate, largest period constant over a count of one
        poll_backlog.push_back(mk(1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
        poll_backlog.push_back(mk(1, 1, 0, 0, 0, 0, 0, 1));
      end
      repeat (RAND_POLLS) poll_backlog.push_back(random_poll());
      wait_drained();
    end

    repeat (END_PAUSE) @(negedge clk);
    if (pending_readouts.size() != 0) begin
      $display("%0d expected readouts never arrived", pending_readouts.size());
      fail_count += pending_readouts.size();
    end
    $display("Sent %0d polls across %0d register settings, checked %0d readouts;",
             polls_taken, settings_run, readouts_seen);
    $display("%0d period readings taken, %0d readings flagged out of band, %0d mismatches.",
             period_reads, rejects, fail_count);
    if (fail_count == 0) begin
      $display("freq_period_meter_postproc verification clean");
    end else begin
      $display("freq_period_meter_postproc verification failed");
    end
    $finish;
  end

endmodule
